// ----- sv/b64sc_pkg.sv -----
// b64sc_pkg: types, constants and alphabet functions for the base64 stream codec
// no dependencies; imported by b64sc_step and base64_stream_codec
package b64sc_pkg;

    localparam int MAX_RES = 4;           // results one item can cause
    localparam int QDEPTH  = 8;           // result queue entries
    localparam int QAW     = 3;           // result queue pointer width
    localparam int QCW     = 4;           // result queue count width

    localparam logic [7:0] CH_PAD = 8'h3D;   // '='

    localparam logic REG_DIRECTION = 1'b0;   // register index of direction

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    // message state; buffer keeps only the bits still held
    typedef struct packed {
        logic [5:0] buf_bits;
        logic [2:0] held;
        logic [1:0] cmf;
        logic       pad;
    } st_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       data_present;
        logic       run_last;
        logic       message_done;
    } res_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)       c = 8'(8'h41 + {2'b00, v});
        else if (v < 6'd52)  c = 8'(8'h47 + {2'b00, v});
        else if (v < 6'd62)  c = 8'({2'b00, v} - 8'd4);
        else if (v == 6'd62) c = 8'h2B;
        else                 c = 8'h2F;
        return c;
    endfunction

    // bit 6 set when the character is in the alphabet
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            r = {1'b1, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h47;
            r = {1'b1, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'h04;
            r = {1'b1, d[5:0]};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// ----- sv/b64sc_step.sv -----
// b64sc_step: one item of encode or decode work, results and next message state
// depends on b64sc_pkg
module b64sc_step
    import b64sc_pkg::*;
(
    input  dir_t       dir,
    input  st_t        st,
    input  logic [7:0] data_in,
    input  logic       message_last,
    output st_t        st_next,
    output res_t       res [MAX_RES],
    output logic [2:0] res_count
);

    logic [13:0] enc_acc;
    logic [11:0] dec_acc;
    logic [6:0]  dec_val;
    logic [5:0]  ch0;
    logic [5:0]  ch1;
    logic [5:0]  fl;
    logic [2:0]  nc;
    logic [2:0]  nf;
    logic [2:0]  np;
    logic [1:0]  cmf_c;
    logic [1:0]  cmf_f;
    logic [7:0]  dec_out;
    logic        dec_has;
    logic [2:0]  total;
    logic [2:0]  cnt;
    logic        bare;
    st_t         nxt;

    always_comb begin
        nxt     = st;
        enc_acc = {st.buf_bits, data_in};
        dec_val = b64_value(data_in);
        dec_acc = {st.buf_bits, dec_val[5:0]};
        ch0     = '0;
        ch1     = '0;
        fl      = '0;
        nc      = '0;
        nf      = '0;
        np      = '0;
        cmf_c   = st.cmf;
        cmf_f   = st.cmf;
        dec_out = '0;
        dec_has = 1'b0;
        if (dir == DIR_ENCODE) begin
            unique case (st.held)
                3'd2: begin
                    nc = 3'd1;
                    ch0 = enc_acc[9:4];
                    nxt.held = 3'd4;
                    nxt.buf_bits = {2'b00, enc_acc[3:0]};
                end
                3'd4: begin
                    nc = 3'd2;
                    ch0 = enc_acc[11:6];
                    ch1 = enc_acc[5:0];
                    nxt.held = 3'd0;
                    nxt.buf_bits = '0;
                end
                default: begin
                    nc = 3'd1;
                    ch0 = enc_acc[7:2];
                    nxt.held = 3'd2;
                    nxt.buf_bits = {4'b0000, enc_acc[1:0]};
                end
            endcase
            cmf_c   = st.cmf + nc[1:0];
            nxt.cmf = cmf_c;
            if (message_last) begin
                if (nxt.held != 3'd0) begin
                    nf = 3'd1;
                    fl = (nxt.held == 3'd2) ? {nxt.buf_bits[1:0], 4'b0000}
                                            : {nxt.buf_bits[3:0], 2'b00};
                end
                cmf_f = cmf_c + nf[1:0];
                np    = {1'b0, 2'(-cmf_f)};
            end
        end else if (!st.pad) begin
            if (data_in == CH_PAD) begin
                nxt.pad = 1'b1;
            end else if (dec_val[6]) begin
                unique case (st.held)
                    3'd2: begin
                        dec_has = 1'b1;
                        dec_out = dec_acc[7:0];
                        nxt.held = 3'd0;
                        nxt.buf_bits = '0;
                    end
                    3'd4: begin
                        dec_has = 1'b1;
                        dec_out = dec_acc[9:2];
                        nxt.held = 3'd2;
                        nxt.buf_bits = {4'b0000, dec_acc[1:0]};
                    end
                    3'd6: begin
                        dec_has = 1'b1;
                        dec_out = dec_acc[11:4];
                        nxt.held = 3'd4;
                        nxt.buf_bits = {2'b00, dec_acc[3:0]};
                    end
                    default: begin
                        nxt.held = 3'd6;
                        nxt.buf_bits = dec_val[5:0];
                    end
                endcase
            end
        end
        if (message_last) nxt = '0;
        st_next = nxt;
    end

    always_comb begin
        if (dir == DIR_ENCODE) total = 3'(nc + nf + np);
        else                   total = {2'b00, dec_has};
        cnt  = (total > 3'(MAX_RES)) ? 3'(MAX_RES) : total;
        bare = message_last && (cnt == 3'd0);
        if (bare) cnt = 3'd1;
        res_count = cnt;
        for (int k = 0; k < MAX_RES; k++) begin
            res[k].data_present = !bare;
            res[k].run_last     = (3'(k) == 3'(cnt - 3'd1));
            res[k].message_done = (3'(k) == 3'(cnt - 3'd1)) && message_last;
            if (bare) begin
                res[k].data_out = '0;
            end else if (dir == DIR_DECODE) begin
                res[k].data_out = dec_out;
            end else if (3'(k) < nc) begin
                res[k].data_out = b64_char((k == 0) ? ch0 : ch1);
            end else if (3'(k) < 3'(nc + nf)) begin
                res[k].data_out = b64_char(fl);
            end else begin
                res[k].data_out = CH_PAD;
            end
        end
    end

endmodule

// ----- sv/base64_stream_codec.sv -----
// an accepted input beat passes the input register, then the result queue;
// one input beat per cycle while the result queue has room for four results;
// one result beat per cycle while m_tready is high
// aresetn (synchronous) clears direction to encode, message state and the queue
// a direction write clears the message state
// base64_stream_codec: top level, input register, state, result queue, apb port
// depends on b64sc_pkg and b64sc_step
module base64_stream_codec
    import b64sc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_in
    input  logic        s_tlast,    // message_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] data_out
    output logic [1:0]  m_tuser,    // [0] data_present, [1] run_last
    output logic        m_tlast,    // message_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dir_t             dir_reg;
    st_t              st_reg;
    st_t              st_next;
    logic             in_valid_reg;
    logic [7:0]       in_data_reg;
    logic             in_last_reg;
    res_t             q_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   cnt_reg;
    logic [QCW-1:0]   cnt_next;
    res_t             res [MAX_RES];
    logic [2:0]       res_count;
    logic             proc_fire;
    logic             pop;
    logic             cfg_we;
    logic             in_fire;

    b64sc_step u_step (
        .dir          (dir_reg),
        .st           (st_reg),
        .data_in      (in_data_reg),
        .message_last (in_last_reg),
        .st_next      (st_next),
        .res          (res),
        .res_count    (res_count)
    );

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'b0, dir_reg} : 32'b0;

    assign proc_fire = in_valid_reg && (cnt_reg <= QCW'(QDEPTH - MAX_RES));
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_fire   = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;

    assign m_tvalid  = (cnt_reg != '0);
    assign m_tdata   = q_reg[rd_ptr_reg].data_out;
    assign m_tuser   = {q_reg[rd_ptr_reg].run_last, q_reg[rd_ptr_reg].data_present};
    assign m_tlast   = q_reg[rd_ptr_reg].message_done;

    always_comb begin
        cnt_next = cnt_reg;
        if (proc_fire) cnt_next = QCW'(cnt_next + QCW'(res_count));
        if (pop)       cnt_next = QCW'(cnt_next - QCW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg      <= DIR_ENCODE;
            st_reg       <= '0;
            in_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            priority if (cfg_we && paddr[2] == REG_DIRECTION) begin
                dir_reg <= dir_t'(pwdata[0]);
                st_reg  <= '0;
            end else if (proc_fire) begin
                st_reg  <= st_next;
            end
            if (in_fire)        in_valid_reg <= 1'b1;
            else if (proc_fire) in_valid_reg <= 1'b0;
            if (proc_fire) wr_ptr_reg <= QAW'(wr_ptr_reg + QAW'(res_count));
            if (pop)       rd_ptr_reg <= QAW'(rd_ptr_reg + QAW'(1));
            cnt_reg <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        for (int k = 0; k < MAX_RES; k++) begin
            if (proc_fire && 3'(k) < res_count) begin
                q_reg[QAW'(wr_ptr_reg + QAW'(k))] <= res[k];
            end
        end
    end

`ifndef SYNTH
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCW'(QDEPTH))
        else $error("result queue count beyond depth");

    a_msg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_last_reg && !cfg_we |=> st_reg == '0)
        else $error("message state not cleared at message end");

    a_enc_held: assert property (@(posedge aclk) disable iff (!aresetn)
        dir_reg == DIR_ENCODE |->
            (st_reg.held == 3'd0 || st_reg.held == 3'd2 || st_reg.held == 3'd4))
        else $error("encode holds an impossible bit count");

    a_enc_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && dir_reg == DIR_ENCODE |-> res_count != 3'd0)
        else $error("encoded byte gave no character");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        QAW'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[QAW-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule
